### design/assert_macros.svh
// Assertion macros used by the top level of the gradient orientation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/hog_pkg.sv
// Types, constants and helper functions for the gradient orientation block.
package hog_pkg;

  localparam int unsigned NumCh   = 3;
  localparam int unsigned NumDirs = 9;
  localparam int unsigned GroupW  = 3;
  localparam int unsigned NumGrp  = NumDirs / GroupW;
  localparam int unsigned PixW    = 8;
  localparam int unsigned GradW   = 9;
  localparam int unsigned MagW    = 9;
  localparam int unsigned BinW    = 5;
  localparam int unsigned CoefW   = 8;
  localparam int unsigned DotW    = 17;
  localparam int unsigned AbsW    = 16;
  localparam int unsigned InW     = NumCh * 4 * PixW;
  localparam int unsigned OutW    = 32;

  localparam logic [BinW-1:0] BinMax = BinW'(2 * NumDirs - 1);

  // Unit directions at 20 degree steps, scaled by 100 and rounded.
  localparam logic signed [CoefW-1:0] DirU [NumDirs] = '{
    8'sd100, 8'sd94, 8'sd77, 8'sd50, 8'sd17, -8'sd17, -8'sd50, -8'sd77, -8'sd94
  };
  localparam logic signed [CoefW-1:0] DirV [NumDirs] = '{
    8'sd0, 8'sd34, 8'sd64, 8'sd87, 8'sd98, 8'sd98, 8'sd87, 8'sd64, 8'sd34
  };

  typedef logic signed [GradW-1:0] grad_t;

  typedef struct packed {
    logic [AbsW-1:0] mag;
    logic [BinW-1:0] bin;
  } hog_cand_t;

  // Magnitude of a central difference; it never exceeds 255.
  function automatic logic [PixW-1:0] abs_grad(input grad_t g);
    grad_t n;
    n = -g;
    return g[GradW-1] ? n[PixW-1:0] : g[PixW-1:0];
  endfunction

endpackage

### design/hog_grad_lane.sv
// One colour channel: central differences and L1 magnitude.
module hog_grad_lane (
  input  logic [hog_pkg::PixW-1:0] left_i,
  input  logic [hog_pkg::PixW-1:0] right_i,
  input  logic [hog_pkg::PixW-1:0] above_i,
  input  logic [hog_pkg::PixW-1:0] below_i,
  output hog_pkg::grad_t           dx_o,
  output hog_pkg::grad_t           dy_o,
  output logic [hog_pkg::MagW-1:0] mag_o
);

  assign dx_o  = $signed({1'b0, right_i}) - $signed({1'b0, left_i});
  assign dy_o  = $signed({1'b0, below_i}) - $signed({1'b0, above_i});
  assign mag_o = {1'b0, hog_pkg::abs_grad(dx_o)} + {1'b0, hog_pkg::abs_grad(dy_o)};

endmodule

### design/hog_dir_lane.sv
// One orientation direction: dot product with the gradient, folded to a bin candidate.
module hog_dir_lane #(
  parameter int unsigned DIR_IDX = 0
) (
  input  hog_pkg::grad_t    dx_i,
  input  hog_pkg::grad_t    dy_i,
  output hog_pkg::hog_cand_t cand_o
);

  logic signed [hog_pkg::DotW-1:0] prod_u;
  logic signed [hog_pkg::DotW-1:0] prod_v;
  logic signed [hog_pkg::DotW-1:0] dot;
  logic signed [hog_pkg::DotW-1:0] dot_neg;

  assign prod_u  = hog_pkg::DotW'(hog_pkg::DirU[DIR_IDX]) * hog_pkg::DotW'(dx_i);
  assign prod_v  = hog_pkg::DotW'(hog_pkg::DirV[DIR_IDX]) * hog_pkg::DotW'(dy_i);
  assign dot     = prod_u + prod_v;
  assign dot_neg = -dot;

  // A negative dot product points the opposite way, nine bins further on.
  assign cand_o.mag = dot[hog_pkg::DotW-1] ? dot_neg[hog_pkg::AbsW-1:0]
                                          : dot[hog_pkg::AbsW-1:0];
  assign cand_o.bin = dot[hog_pkg::DotW-1] ? hog_pkg::BinW'(DIR_IDX + hog_pkg::NumDirs)
                                          : hog_pkg::BinW'(DIR_IDX);

endmodule

### design/hog_bin_merge.sv
// Picks the strongest of a group of direction candidates; the earliest wins a tie.
module hog_bin_merge (
  input  hog_pkg::hog_cand_t cand_i [hog_pkg::GroupW],
  output hog_pkg::hog_cand_t best_o
);

  always_comb begin
    best_o = cand_i[0];
    for (int i = 1; i < hog_pkg::GroupW; i++) begin
      if (cand_i[i].mag > best_o.mag) begin
        best_o = cand_i[i];
      end
    end
  end

endmodule

### design/hog_gradient_orientation_bin.sv
// Top level of the gradient orientation binning block.
// Each input beat carries the left, right, above and below neighbours of one pixel in
// three 8-bit colour channels. Three gradient lanes form dx, dy and the L1 magnitude,
// the channel with the strictly largest magnitude is kept (earliest on a tie), and
// nine direction lanes take dot products that a registered tree merges into one of
// 18 orientation bins.
// Output beats carry the magnitude, the bin and the chosen dx and dy.
// A result passes through the stage registers s1 to s4 and then the output register.
// Throughput: one beat per clock unless stalled; five beats held, one per stage.
// in_tready is low only when every stage holds a beat and the receiver stalls;
// bubbles in the pipeline are closed up while the output is held.
// A stalled output beat holds its data until out_tready is seen.
// Reset clears all stage valid flags, so no beat is presented after reset.
// No configuration is needed; every pixel is independent.
module hog_gradient_orientation_bin (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // c0_left, c0_right, c0_above, c0_below, c1_left .. c1_below, c2_left .. c2_below
  input  logic [hog_pkg::InW-1:0]    in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // magnitude[8:0], orient_bin[13:9], chosen_dx[22:14], chosen_dy[31:23]
  output logic [hog_pkg::OutW-1:0]   out_tdata
);

  `include "assert_macros.svh"

  // Stage 1: per-channel gradients.
  hog_pkg::grad_t              lane_dx  [hog_pkg::NumCh];
  hog_pkg::grad_t              lane_dy  [hog_pkg::NumCh];
  logic [hog_pkg::MagW-1:0]    lane_mag [hog_pkg::NumCh];
  hog_pkg::grad_t              s1_dx_r  [hog_pkg::NumCh];
  hog_pkg::grad_t              s1_dy_r  [hog_pkg::NumCh];
  logic [hog_pkg::MagW-1:0]    s1_mag_r [hog_pkg::NumCh];
  logic                        s1_v_r;

  // Stage 2: chosen channel.
  hog_pkg::grad_t              sel_dx_nxt;
  hog_pkg::grad_t              sel_dy_nxt;
  logic [hog_pkg::MagW-1:0]    sel_mag_nxt;
  hog_pkg::grad_t              s2_dx_r;
  hog_pkg::grad_t              s2_dy_r;
  logic [hog_pkg::MagW-1:0]    s2_mag_r;
  logic                        s2_v_r;

  // Stage 3: direction candidates.
  hog_pkg::hog_cand_t          dir_cand [hog_pkg::NumDirs];
  hog_pkg::hog_cand_t          s3_cand_r [hog_pkg::NumDirs];
  hog_pkg::grad_t              s3_dx_r;
  hog_pkg::grad_t              s3_dy_r;
  logic [hog_pkg::MagW-1:0]    s3_mag_r;
  logic                        s3_v_r;

  // Stage 4: group winners.
  hog_pkg::hog_cand_t          grp_best [hog_pkg::NumGrp];
  hog_pkg::hog_cand_t          s4_cand_r [hog_pkg::NumGrp];
  hog_pkg::grad_t              s4_dx_r;
  hog_pkg::grad_t              s4_dy_r;
  logic [hog_pkg::MagW-1:0]    s4_mag_r;
  logic                        s4_v_r;

  // Stage 5: output register.
  hog_pkg::hog_cand_t          fin_best;
  hog_pkg::grad_t              out_dx_r;
  hog_pkg::grad_t              out_dy_r;
  logic [hog_pkg::MagW-1:0]    out_mag_r;
  logic [hog_pkg::BinW-1:0]    out_bin_r;
  logic                        out_v_r;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // A stage moves on when it is empty or the stage after it moves on.
  assign rdy5      = !out_v_r || out_tready;
  assign rdy4      = !s4_v_r  || rdy5;
  assign rdy3      = !s3_v_r  || rdy4;
  assign rdy2      = !s2_v_r  || rdy3;
  assign rdy1      = !s1_v_r  || rdy2;
  assign in_tready = rdy1;

  for (genvar c = 0; c < hog_pkg::NumCh; c++) begin : g_grad
    hog_grad_lane u_lane (
      .left_i  (in_tdata[(c*4+0)*hog_pkg::PixW +: hog_pkg::PixW]),
      .right_i (in_tdata[(c*4+1)*hog_pkg::PixW +: hog_pkg::PixW]),
      .above_i (in_tdata[(c*4+2)*hog_pkg::PixW +: hog_pkg::PixW]),
      .below_i (in_tdata[(c*4+3)*hog_pkg::PixW +: hog_pkg::PixW]),
      .dx_o    (lane_dx[c]),
      .dy_o    (lane_dy[c]),
      .mag_o   (lane_mag[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_dx_r  <= lane_dx;
      s1_dy_r  <= lane_dy;
      s1_mag_r <= lane_mag;
    end
  end

  // Channel 0 is the default; a later channel must be strictly larger to win.
  always_comb begin
    sel_dx_nxt  = s1_dx_r[0];
    sel_dy_nxt  = s1_dy_r[0];
    sel_mag_nxt = s1_mag_r[0];
    for (int c = 1; c < hog_pkg::NumCh; c++) begin
      if (s1_mag_r[c] > sel_mag_nxt) begin
        sel_dx_nxt  = s1_dx_r[c];
        sel_dy_nxt  = s1_dy_r[c];
        sel_mag_nxt = s1_mag_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_dx_r  <= sel_dx_nxt;
      s2_dy_r  <= sel_dy_nxt;
      s2_mag_r <= sel_mag_nxt;
    end
  end

  for (genvar d = 0; d < hog_pkg::NumDirs; d++) begin : g_dir
    hog_dir_lane #(
      .DIR_IDX (d)
    ) u_dir (
      .dx_i   (s2_dx_r),
      .dy_i   (s2_dy_r),
      .cand_o (dir_cand[d])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_cand_r <= dir_cand;
      s3_dx_r   <= s2_dx_r;
      s3_dy_r   <= s2_dy_r;
      s3_mag_r  <= s2_mag_r;
    end
  end

  // Groups keep direction order, so the tie rule of the serial search is preserved.
  for (genvar g = 0; g < hog_pkg::NumGrp; g++) begin : g_grp
    hog_pkg::hog_cand_t grp_in [hog_pkg::GroupW];
    for (genvar k = 0; k < hog_pkg::GroupW; k++) begin : g_in
      assign grp_in[k] = s3_cand_r[g*hog_pkg::GroupW + k];
    end
    hog_bin_merge u_merge (
      .cand_i (grp_in),
      .best_o (grp_best[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (rdy4) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_cand_r <= grp_best;
      s4_dx_r   <= s3_dx_r;
      s4_dy_r   <= s3_dy_r;
      s4_mag_r  <= s3_mag_r;
    end
  end

  hog_bin_merge u_final (
    .cand_i (s4_cand_r),
    .best_o (fin_best)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy5) begin
      out_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_bin_r <= fin_best.bin;
      out_dx_r  <= s4_dx_r;
      out_dy_r  <= s4_dy_r;
      out_mag_r <= s4_mag_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_dy_r, out_dx_r, out_bin_r, out_mag_r};

  `ASSERT_CLK_ALWAYS(a_idle_after_reset, !rst_n |=> !out_tvalid, "beat presented after reset")
  `ASSERT_CLK(a_bin_range, out_tvalid |-> (out_bin_r <= hog_pkg::BinMax), "bin out of range")
  `ASSERT_CLK(a_mag_match, out_tvalid |-> (out_mag_r == ({1'b0, hog_pkg::abs_grad(out_dx_r)} + {1'b0, hog_pkg::abs_grad(out_dy_r)})), "magnitude does not match gradient")
  `ASSERT_CLK(a_zero_bin, (out_tvalid && (out_mag_r == '0)) |-> (out_bin_r == '0), "zero gradient not in bin zero")

endmodule

### tb/sv/tb_hog_gradient_orientation_bin.sv
// Self-checking testbench for the 18-bin gradient orientation block.
`timescale 1ns / 100ps

module tb_hog_gradient_orientation_bin;

  localparam int NumProbes   = 22;
  localparam int RandomBeats = 1950;
  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 20;

  // Result beat, packed in the same order as out_tdata.
  typedef struct packed {
    logic signed [hog_pkg::GradW-1:0] dy;
    logic signed [hog_pkg::GradW-1:0] dx;
    logic [hog_pkg::BinW-1:0]         bin;
    logic [hog_pkg::MagW-1:0]         mag;
  } orient_t;

  typedef enum int {PIX_NOISE, PIX_FLAT, PIX_EXTREME, PIX_TWIN} pixel_kind_e;

  // Direction cosines and sines, scaled by 100, at 20 degree steps.
  const int cos100 [9] = '{100, 94, 77, 50, 17, -17, -50, -77, -94};
  const int sin100 [9] = '{0, 34, 64, 87, 98, 98, 87, 64, 34};

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [hog_pkg::InW-1:0]    in_tdata;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [hog_pkg::OutW-1:0]   out_tdata;

  orient_t pending_bins [$];
  int      mismatches = 0;
  int      cycles = 0;
  int      ready_mode = 0;
  int      mode_left = 0;
  int      ready_phase = 0;
  orient_t seen_beat;
  orient_t due_beat;

  // Neighbours per row: c0 left, right, above, below, then c1 and c2 in the same order.
  int probe_px [NumProbes][12] = '{
    '{  0,   0,   0,   0,    0,   0,   0,   0,    0,   0,   0,   0},
    '{255, 255, 255, 255,  255, 255, 255, 255,  255, 255, 255, 255},
    '{  0, 255,   0,   0,    0,   0,   0,   0,    0,   0,   0,   0},
    '{255,   0,   0,   0,    0,   0,   0,   0,    0,   0,   0,   0},
    '{  0,   0,   0, 255,    0,   0,   0,   0,    0,   0,   0,   0},
    '{  0,   0, 255,   0,    0,   0,   0,   0,    0,   0,   0,   0},
    '{  0, 255,   0, 255,    0,   0,   0,   0,    0,   0,   0,   0},
    '{255,   0, 255,   0,    0,   0,   0,   0,    0,   0,   0,   0},
    '{  0,   0,   0,   0,    0, 255,   0,   0,    0,   0,   0,   0},
    '{  0,   0,   0,   0,    0,   0,   0,   0,    0,   0, 255,   0},
    '{  0,  10,   0,   0,    0,   0,   0,  10,    0,   0,   0,   0},
    '{  3,   4,   0,   0,   50,  30,   0,   0,    0,   0,   0,  20},
    '{  0,   5,   0,   0,    0,   0,   0,   5,    5,   0,   0,   0},
    '{100,   0,   0,   0,    0,   0,   0, 100,    0,   0,   0, 101},
    '{  0,   0,   0,  50,    0,   0,   0,   0,    0,   0,   0,   0},
    '{  0,   1,   0,   0,    0,   0,   0,   0,    0,   0,   0,   0},
    '{  0,   0,   1,   0,    0,   0,   0,   0,    0,   0,   0,   0},
    '{ 37, 200,  90,  12,    5,   9, 250,   3,  128, 127,  64,  66},
    '{255,   0,   0, 255,    0,   0,   0,   0,    0,   0,   0,   0},
    '{  0, 255, 255,   0,    0,   0,   0,   0,    0,   0,   0,   0},
    '{  0, 255,   0,   0,    0, 100,   0, 155,  255,   0,   0,   0},
    '{170,  85, 170,  85,   85, 170,  85, 170,  170, 170,  85,  85}
  };

  // Typed-in flag, magnitude, bin, dx, dy; rows without the flag go to the predictor.
  int probe_want [NumProbes][5] = '{
    '{1,   0,  0,    0,    0},
    '{1,   0,  0,    0,    0},
    '{1, 255,  0,  255,    0},
    '{1, 255,  9, -255,    0},
    '{1, 255,  4,    0,  255},
    '{1, 255, 13,    0, -255},
    '{1, 510,  2,  255,  255},
    '{1, 510, 11, -255, -255},
    '{1, 255,  0,  255,    0},
    '{1, 255, 13,    0, -255},
    '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}
  };

  hog_gradient_orientation_bin dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // Strongest channel, then the direction whose projection is largest in either sense.
  function automatic orient_t orient_of_pixel(input logic [hog_pkg::InW-1:0] px);
    int      ch;
    int      o;
    int      gx;
    int      gy;
    int      l1;
    int      dot;
    int      best;
    int      win_mag;
    int      win_dx;
    int      win_dy;
    int      bin;
    orient_t r;
    win_mag = 0;
    win_dx  = 0;
    win_dy  = 0;
    for (ch = 0; ch < 3; ch++) begin
      gx = int'(px[ch*32+8 +: 8]) - int'(px[ch*32 +: 8]);
      gy = int'(px[ch*32+24 +: 8]) - int'(px[ch*32+16 +: 8]);
      l1 = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (ch == 0 || l1 > win_mag) begin
        win_mag = l1;
        win_dx  = gx;
        win_dy  = gy;
      end
    end
    best = 0;
    bin  = 0;
    for (o = 0; o < 9; o++) begin
      dot = cos100[o] * win_dx + sin100[o] * win_dy;
      if (dot > best) begin
        best = dot;
        bin  = o;
      end else if (-dot > best) begin
        best = -dot;
        bin  = o + 9;
      end
    end
    r.mag = win_mag[hog_pkg::MagW-1:0];
    r.bin = bin[hog_pkg::BinW-1:0];
    r.dx  = win_dx[hog_pkg::GradW-1:0];
    r.dy  = win_dy[hog_pkg::GradW-1:0];
    return r;
  endfunction

  function automatic logic [hog_pkg::InW-1:0] random_pixel();
    logic [hog_pkg::InW-1:0] px;
    logic [31:0]             lane;
    pixel_kind_e             kind;
    int                      k;
    int                      val;
    int                      base;
    int                      src;
    int                      dst;
    kind = pixel_kind_e'($urandom_range(0, 3));
    px   = {$urandom, $urandom, $urandom};
    case (kind)
      PIX_FLAT: begin
        // Neighbours close together: small gradients, frequent ties and zero magnitude.
        for (k = 0; k < 12; k++) begin
          if (k % 4 == 0) base = $urandom_range(0, 255);
          val = base + int'($urandom_range(0, 8)) - 4;
          if (val < 0) val = 0;
          if (val > 255) val = 255;
          px[k*8 +: 8] = val[7:0];
        end
      end
      PIX_EXTREME: begin
        for (k = 0; k < 12; k++) begin
          case ($urandom_range(0, 2))
            0: px[k*8 +: 8] = 8'h00;
            1: px[k*8 +: 8] = 8'hff;
            default: px[k*8 +: 8] = 8'($urandom);
          endcase
        end
      end
      PIX_TWIN: begin
        // A mirrored copy of one channel in another gives an equal magnitude.
        src  = $urandom_range(0, 2);
        dst  = (src + int'($urandom_range(1, 2))) % 3;
        lane = px[src*32 +: 32];
        if ($urandom_range(0, 1)) lane = {lane[31:16], lane[7:0], lane[15:8]};
        if ($urandom_range(0, 1)) lane = {lane[23:16], lane[31:24], lane[15:0]};
        px[dst*32 +: 32] = lane;
      end
      default: ;
    endcase
    return px;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic push_pixel(input logic [hog_pkg::InW-1:0] px, input bit typed,
                            input orient_t want);
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    pending_bins.push_back(typed ? want : orient_of_pixel(px));
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Receiver: always ready, coin toss, short periodic stalls or long stalls.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (ready_phase % 7) > 1;
      default: out_tready <= (ready_phase % 32) >= 24;
    endcase
    ready_phase <= ready_phase + 1;
  end

  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      seen_beat = orient_t'(out_tdata);
      if (pending_bins.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, got %h", $time, out_tdata);
      end else begin
        due_beat = pending_bins.pop_front();
        check_field("magnitude", due_beat.mag, seen_beat.mag);
        check_field("orient_bin", due_beat.bin, seen_beat.bin);
        check_field("chosen_dx", due_beat.dx, seen_beat.dx);
        check_field("chosen_dy", due_beat.dy, seen_beat.dy);
      end
    end
    if (cycles > CycleLimit) begin
      $display("hog_gradient_orientation_bin: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [hog_pkg::InW-1:0] px;
    orient_t                 want;
    int                      row;
    int                      k;
    int                      sent;
    int                      burst;
    int                      gap;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < NumProbes; row++) begin
      for (k = 0; k < 12; k++) px[k*8 +: 8] = probe_px[row][k][7:0];
      want.mag = probe_want[row][1][hog_pkg::MagW-1:0];
      want.bin = probe_want[row][2][hog_pkg::BinW-1:0];
      want.dx  = probe_want[row][3][hog_pkg::GradW-1:0];
      want.dy  = probe_want[row][4][hog_pkg::GradW-1:0];
      push_pixel(px, probe_want[row][0] != 0, want);
    end

    // Bursts of random length; about a third of them run straight into the next.
    sent = 0;
    while (sent < RandomBeats) begin
      burst = $urandom_range(1, 40);
      for (k = 0; k < burst && sent < RandomBeats; k++) begin
        push_pixel(random_pixel(), 1'b0, want);
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= {$urandom, $urandom, $urandom};
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 1'b0;

    while (pending_bins.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("hog_gradient_orientation_bin: match");
    end else begin
      $display("hog_gradient_orientation_bin: mismatch");
    end
    $finish;
  end

endmodule
